@@ rtl/mevmidi_pkg.sv @@
`default_nettype none

package mevmidi_pkg;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // midi event bytes
  localparam logic [7:0] MIDI_NOTE_ON  = 8'h90;
  localparam logic [7:0] MIDI_CTRL     = 8'hB0;
  localparam logic [7:0] MIDI_PROG     = 8'hC0;
  localparam logic [7:0] MIDI_BEND     = 8'hE0;
  localparam logic [7:0] CC_VOLUME     = 8'h07;
  localparam logic [7:0] CC_PAN        = 8'h0A;
  localparam logic [7:0] CC_DRUM       = 8'h67;
  localparam logic [7:0] CC_LOOP       = 8'h6F;
  localparam logic [7:0] META_PREFIX   = 8'hFF;
  localparam logic [7:0] META_PORT     = 8'h20;
  localparam logic [7:0] META_EOT      = 8'h2F;
  localparam logic [7:0] NO_NOTE       = 8'hFF;

  // source track commands
  localparam logic [7:0] CMD_NOTE_OFF   = 8'h90;
  localparam logic [7:0] CMD_TRACK_END  = 8'h91;
  localparam logic [7:0] CMD_PROGRAM    = 8'h92;
  localparam logic [7:0] CMD_BEND       = 8'h95;
  localparam logic [7:0] CMD_VOLUME     = 8'h96;
  localparam logic [7:0] CMD_DRUM       = 8'h97;
  localparam logic [7:0] CMD_LOOP_BACK  = 8'h98;
  localparam logic [7:0] CMD_LAST_OFF   = 8'h99;
  localparam logic [7:0] CMD_PAN        = 8'h9B;
  localparam logic [7:0] CMD_LOOP_START = 8'h9C;
  localparam logic [7:0] CMD_CTRL       = 8'h9D;
  localparam logic [7:0] CMD_CTRL_VALUE = 8'h9E;

  // parser phase
  typedef enum logic [3:0] {
    PH_DELAY = 4'b0001,
    PH_CMD   = 4'b0010,
    PH_PARAM = 4'b0100,
    PH_ENDED = 4'b1000
  } phase_e;

  // byte templates the back end plays out
  typedef enum logic [2:0] {
    JOB_ONE,        // b
    JOB_TWO,        // s b
    JOB_THREE,      // s a b
    JOB_CHSEL,      // ff 20 01 b
    JOB_END,        // ff 2f 00
    JOB_LOOP_BACK,  // s 6f 01 00 ff 2f 00
    JOB_RENOTE      // s a 00 00 s a b
  } job_e;

  typedef struct packed {
    job_e       op;
    logic [7:0] s;
    logic [7:0] a;
    logic [7:0] b;
    logic       dno;
    logic       unk;
  } job_t;

  // index of the final byte of a job
  function automatic logic [2:0] job_last(input job_e op);
    logic [2:0] r;
    unique case (op)
      JOB_ONE:       r = 3'd0;
      JOB_TWO:       r = 3'd1;
      JOB_THREE:     r = 3'd2;
      JOB_CHSEL:     r = 3'd3;
      JOB_END:       r = 3'd2;
      JOB_LOOP_BACK: r = 3'd6;
      JOB_RENOTE:    r = 3'd6;
      default:       r = 3'd0;
    endcase
    return r;
  endfunction

  // byte of a job at a given index
  function automatic logic [7:0] job_byte(input job_t j, input logic [2:0] idx);
    logic [7:0] r;
    r = 8'h00;
    unique case (j.op)
      JOB_ONE: r = j.b;
      JOB_TWO: r = (idx == 3'd0) ? j.s : j.b;
      JOB_THREE: begin
        unique case (idx)
          3'd0:    r = j.s;
          3'd1:    r = j.a;
          default: r = j.b;
        endcase
      end
      JOB_CHSEL: begin
        unique case (idx)
          3'd0:    r = META_PREFIX;
          3'd1:    r = META_PORT;
          3'd2:    r = 8'h01;
          default: r = j.b;
        endcase
      end
      JOB_END: begin
        unique case (idx)
          3'd0:    r = META_PREFIX;
          3'd1:    r = META_EOT;
          default: r = 8'h00;
        endcase
      end
      JOB_LOOP_BACK: begin
        unique case (idx)
          3'd0:    r = j.s;
          3'd1:    r = CC_LOOP;
          3'd2:    r = 8'h01;
          3'd3:    r = 8'h00;
          3'd4:    r = META_PREFIX;
          3'd5:    r = META_EOT;
          default: r = 8'h00;
        endcase
      end
      JOB_RENOTE: begin
        unique case (idx)
          3'd0, 3'd4: r = j.s;
          3'd1, 3'd5: r = j.a;
          3'd6:       r = j.b;
          default:    r = 8'h00;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/music_event_to_midi_transcoder_top.sv @@
// channel | direction | handshake                 | payload
// in      | input     | in_valid_i / in_stall_o   | data_byte_i, track_start_i
// out     | output    | out_valid_o / out_stall_i | out_byte_o plus four flag outputs
//
// the front parses one byte per cycle while the job queue has room
// the back emits one result byte per cycle while out_stall_i is low, so an input byte yields 0 to 7 result bytes
// when the back is idle, the first result byte is registered in the job queue and then in the output register
// rst_ni clears the parser, the queue and the output valid
// in_stall_o rises only when the queue is full; out_stall_i holds the output register

`default_nettype none

module music_event_to_midi_transcoder_top
  import mevmidi_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       track_start_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            last_of_run_o,
  output logic            track_done_o,
  output logic            unknown_command_o,
  output logic            double_note_off_o
);

  logic accept;
  logic push, pop, empty, full;
  job_t job_in, job_head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // parser
  mevmidi_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .track_start_i (track_start_i),
    .push_o        (push),
    .job_o         (job_in)
  );

  // job queue
  mevmidi_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .head_o  (job_head),
    .empty_o (empty),
    .full_o  (full)
  );

  // byte emitter
  mevmidi_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_i            (job_head),
    .empty_i           (empty),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_byte_o        (out_byte_o),
    .last_of_run_o     (last_of_run_o),
    .track_done_o      (track_done_o),
    .unknown_command_o (unknown_command_o),
    .double_note_off_o (double_note_off_o)
  );

endmodule

`default_nettype wire

@@ rtl/mevmidi_front.sv @@
`default_nettype none

module mevmidi_front
  import mevmidi_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       track_start_i,
  output logic            push_o,
  output job_t            job_o
);

  phase_e     ph_q, ph_d;
  logic [7:0] pend_q, pend_d;
  logic [3:0] chan_q, chan_d;
  logic [7:0] prev_q, prev_d;

  phase_e     ph_eff;
  logic [7:0] pend_eff;
  logic [7:0] prev_eff;
  logic       has_job;
  logic [7:0] b;

  assign b = data_byte_i;

  // track start resets the parser phase, pending command and previous note before the byte is used
  always_comb begin
    ph_eff   = track_start_i ? PH_DELAY : ph_q;
    pend_eff = track_start_i ? 8'h00 : pend_q;
    prev_eff = track_start_i ? NO_NOTE : prev_q;
  end

  // classify the byte and update the parser
  always_comb begin
    ph_d    = ph_eff;
    pend_d  = pend_eff;
    chan_d  = chan_q;
    prev_d  = prev_eff;
    has_job = 1'b0;
    job_o   = '{op: JOB_ONE, s: 8'h00, a: 8'h00, b: b, dno: 1'b0, unk: 1'b0};

    unique case (ph_eff)
      PH_DELAY: begin
        has_job = 1'b1;
        if (!b[7]) ph_d = PH_CMD;
      end
      PH_CMD: begin
        priority if (!b[7]) begin
          pend_d = b;
          ph_d   = PH_PARAM;
        end else if (b[6:4] == 3'b000) begin
          chan_d   = b[3:0];
          has_job  = 1'b1;
          job_o.op = JOB_CHSEL;
          job_o.b  = {4'h0, b[3:0]};
          ph_d     = PH_DELAY;
        end else begin
          unique case (b)
            CMD_NOTE_OFF, CMD_PROGRAM, CMD_BEND, CMD_VOLUME, CMD_DRUM, CMD_PAN,
            CMD_CTRL: begin
              pend_d = b;
              ph_d   = PH_PARAM;
            end
            CMD_LOOP_START: begin
              has_job  = 1'b1;
              job_o.op = JOB_THREE;
              job_o.s  = MIDI_CTRL | {4'h0, chan_q};
              job_o.a  = CC_LOOP;
              job_o.b  = 8'h00;
              ph_d     = PH_DELAY;
            end
            CMD_LOOP_BACK: begin
              has_job  = 1'b1;
              job_o.op = JOB_LOOP_BACK;
              job_o.s  = MIDI_CTRL | {4'h0, chan_q};
              ph_d     = PH_ENDED;
            end
            CMD_TRACK_END: begin
              has_job  = 1'b1;
              job_o.op = JOB_END;
              ph_d     = PH_ENDED;
            end
            CMD_LAST_OFF: begin
              has_job   = 1'b1;
              job_o.op  = JOB_THREE;
              job_o.s   = MIDI_NOTE_ON | {4'h0, chan_q};
              job_o.a   = prev_eff;
              job_o.b   = 8'h00;
              job_o.dno = (prev_eff == NO_NOTE);
              prev_d    = NO_NOTE;
              ph_d      = PH_DELAY;
            end
            default: begin
              // unknown command: flag it, drop the byte, stay in this phase
              has_job   = 1'b1;
              job_o.op  = JOB_ONE;
              job_o.b   = 8'h00;
              job_o.unk = 1'b1;
            end
          endcase
        end
      end
      PH_PARAM: begin
        ph_d = PH_DELAY;
        if (!pend_eff[7]) begin
          // note with velocity, repeated note gets a note-off first
          has_job  = 1'b1;
          job_o.op = (prev_eff == pend_eff) ? JOB_RENOTE : JOB_THREE;
          job_o.s  = MIDI_NOTE_ON | {4'h0, chan_q};
          job_o.a  = pend_eff;
          prev_d   = pend_eff;
        end else begin
          unique case (pend_eff)
            CMD_NOTE_OFF: begin
              has_job  = 1'b1;
              job_o.op = JOB_THREE;
              job_o.s  = MIDI_NOTE_ON | {4'h0, chan_q};
              job_o.a  = b;
              job_o.b  = 8'h00;
            end
            CMD_PROGRAM: begin
              has_job  = 1'b1;
              job_o.op = JOB_TWO;
              job_o.s  = MIDI_PROG | {4'h0, chan_q};
            end
            CMD_BEND: begin
              has_job  = 1'b1;
              job_o.op = JOB_THREE;
              job_o.s  = MIDI_BEND | {4'h0, chan_q};
              job_o.a  = 8'h00;
            end
            CMD_VOLUME: begin
              has_job  = 1'b1;
              job_o.op = JOB_THREE;
              job_o.s  = MIDI_CTRL | {4'h0, chan_q};
              job_o.a  = CC_VOLUME;
            end
            CMD_DRUM: begin
              has_job  = 1'b1;
              job_o.op = JOB_THREE;
              job_o.s  = MIDI_CTRL | {4'h0, chan_q};
              job_o.a  = CC_DRUM;
            end
            CMD_PAN: begin
              has_job  = 1'b1;
              job_o.op = JOB_THREE;
              job_o.s  = MIDI_CTRL | {4'h0, chan_q};
              job_o.a  = CC_PAN;
            end
            CMD_CTRL: begin
              has_job  = 1'b1;
              job_o.op = JOB_TWO;
              job_o.s  = MIDI_CTRL | {4'h0, chan_q};
              pend_d   = CMD_CTRL_VALUE;
              ph_d     = PH_PARAM;
            end
            CMD_CTRL_VALUE: begin
              has_job  = 1'b1;
              job_o.op = JOB_ONE;
              pend_d   = CMD_CTRL;
            end
            default: begin
              has_job = 1'b0;
            end
          endcase
        end
      end
      default: begin
        // ended: nothing until the next track start
        has_job = 1'b0;
      end
    endcase
  end

  assign push_o = accept_i && has_job;

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_DELAY;
      pend_q <= 8'h00;
      chan_q <= 4'h0;
      prev_q <= NO_NOTE;
    end else if (accept_i) begin
      ph_q   <= ph_d;
      pend_q <= pend_d;
      chan_q <= chan_d;
      prev_q <= prev_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/mevmidi_queue.sv @@
`default_nettype none

module mevmidi_queue
  import mevmidi_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      job_i,
  input  wire logic pop_i,
  output job_t      head_o,
  output logic      empty_o,
  output logic      full_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(Depth - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(Depth);

  job_t          mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == FULL_CNT);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= job_i;
  end

endmodule

`default_nettype wire

@@ rtl/mevmidi_back.sv @@
`default_nettype none

module mevmidi_back
  import mevmidi_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  job_t            head_i,
  input  wire logic       empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            last_of_run_o,
  output logic            track_done_o,
  output logic            unknown_command_o,
  output logic            double_note_off_o
);

  logic [2:0] idx_q;
  logic       valid_q;
  logic       load;
  logic       is_last;
  logic [7:0] byte_q;
  logic       lor_q, done_q, unk_q, dno_q;

  assign load    = !valid_q || !out_stall_i;
  assign is_last = (idx_q == job_last(head_i.op));
  assign pop_o   = load && !empty_i && is_last;

  // byte index within the current job and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 3'd0;
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= !empty_i;
      if (!empty_i) idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load && !empty_i) begin
      byte_q <= job_byte(head_i, idx_q);
      lor_q  <= is_last;
      done_q <= is_last && ((head_i.op == JOB_END) || (head_i.op == JOB_LOOP_BACK));
      unk_q  <= head_i.unk;
      dno_q  <= head_i.dno;
    end
  end

  assign out_valid_o       = valid_q;
  assign out_byte_o        = byte_q;
  assign last_of_run_o     = lor_q;
  assign track_done_o      = done_q;
  assign unknown_command_o = unk_q;
  assign double_note_off_o = dno_q;

endmodule

`default_nettype wire

@@ rtl/mevmidi_checker.sv @@
`default_nettype none

module mevmidi_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       last_of_run_o,
  input wire logic       track_done_o,
  input wire logic       unknown_command_o,
  input wire logic       double_note_off_o
);

  // a stalled output transaction stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o))
    else $error("stalled output changed");

  // end of track closes the run with a zero byte
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && track_done_o |-> last_of_run_o && (out_byte_o == 8'h00))
    else $error("track done not on final zero byte");

  // unknown command is a lone zero byte
  a_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unknown_command_o |-> last_of_run_o && (out_byte_o == 8'h00)
      && !track_done_o && !double_note_off_o)
    else $error("unknown command flag malformed");

  // double note off only on the note-off triple, never on track end
  a_dno: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && double_note_off_o && last_of_run_o |-> (out_byte_o == 8'h00)
      && !track_done_o)
    else $error("double note off flag malformed");

endmodule

bind music_event_to_midi_transcoder_top mevmidi_checker u_mevmidi_checker (.*);

`default_nettype wire

@@ sim/midi_stream_checker.sv @@
`default_nettype none

module midi_stream_checker
  import mevmidi_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_stall_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       track_start_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_stall_i,
  input  wire logic [7:0] out_byte_i,
  input  wire logic       last_of_run_i,
  input  wire logic       track_done_i,
  input  wire logic       unknown_command_i,
  input  wire logic       double_note_off_i,
  output int              mismatches_o,
  output int              pending_o,
  output int              checked_o
);

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       done;
    logic       unk;
    logic       dno;
  } midi_byte_t;

  // expected midi bytes in output order
  midi_byte_t expected_bytes_q[$];
  // bytes caused by the source byte being predicted
  midi_byte_t run_q[$];
  logic       run_dno;
  logic       run_unk;
  logic       run_done;

  // transcoder state as predicted
  phase_e     phase_q;
  logic [7:0] pend_cmd_q;
  logic [3:0] chan_q;
  logic [7:0] prev_note_q;

  midi_byte_t want;

  function automatic logic [7:0] on_chan(input logic [7:0] status);
    return status | {4'h0, chan_q};
  endfunction

  function automatic void add_byte(input logic [7:0] v);
    midi_byte_t e;
    e       = '0;
    e.value = v;
    e.dno   = run_dno;
    e.unk   = run_unk;
    run_q.push_back(e);
  endfunction

  // ff 2f 00 meta event
  function automatic void add_end_of_track();
    add_byte(META_PREFIX);
    add_byte(META_EOT);
    add_byte(8'h00);
    run_done = 1'b1;
  endfunction

  // midi bytes caused by one source byte
  function automatic void predict_midi_run(input logic [7:0] b, input logic start);
    midi_byte_t e;
    run_q.delete();
    run_dno  = 1'b0;
    run_unk  = 1'b0;
    run_done = 1'b0;
    if (start) begin
      phase_q     = PH_DELAY;
      prev_note_q = NO_NOTE;
      pend_cmd_q  = 8'h00;
    end
    case (phase_q)
      // delay bytes pass through
      PH_DELAY: begin
        add_byte(b);
        if (!b[7]) phase_q = PH_CMD;
      end
      PH_CMD: begin
        if (!b[7]) begin
          pend_cmd_q = b;
          phase_q    = PH_PARAM;
        end else if (b[7:4] == 4'h8) begin
          chan_q = b[3:0];
          add_byte(META_PREFIX);
          add_byte(META_PORT);
          add_byte(8'h01);
          add_byte({4'h0, b[3:0]});
          phase_q = PH_DELAY;
        end else begin
          case (b)
            CMD_NOTE_OFF, CMD_PROGRAM, CMD_BEND, CMD_VOLUME, CMD_DRUM, CMD_PAN,
            CMD_CTRL: begin
              pend_cmd_q = b;
              phase_q    = PH_PARAM;
            end
            CMD_LOOP_START: begin
              add_byte(on_chan(MIDI_CTRL));
              add_byte(CC_LOOP);
              add_byte(8'h00);
              phase_q = PH_DELAY;
            end
            CMD_LOOP_BACK: begin
              add_byte(on_chan(MIDI_CTRL));
              add_byte(CC_LOOP);
              add_byte(8'h01);
              add_byte(8'h00);
              add_end_of_track();
              phase_q = PH_ENDED;
            end
            CMD_TRACK_END: begin
              add_end_of_track();
              phase_q = PH_ENDED;
            end
            CMD_LAST_OFF: begin
              // flagged when no note is sounding
              run_dno = (prev_note_q == NO_NOTE);
              add_byte(on_chan(MIDI_NOTE_ON));
              add_byte(prev_note_q);
              add_byte(8'h00);
              prev_note_q = NO_NOTE;
              phase_q     = PH_DELAY;
            end
            default: begin
              // unknown command is dropped, parser stays put
              run_unk = 1'b1;
              add_byte(8'h00);
            end
          endcase
        end
      end
      PH_PARAM: begin
        phase_q = PH_DELAY;
        if (!pend_cmd_q[7]) begin
          // repeated note gets a note-off and zero delay first
          if (prev_note_q == pend_cmd_q) begin
            add_byte(on_chan(MIDI_NOTE_ON));
            add_byte(prev_note_q);
            add_byte(8'h00);
            add_byte(8'h00);
          end
          prev_note_q = pend_cmd_q;
          add_byte(on_chan(MIDI_NOTE_ON));
          add_byte(pend_cmd_q);
          add_byte(b);
        end else begin
          case (pend_cmd_q)
            CMD_NOTE_OFF: begin
              add_byte(on_chan(MIDI_NOTE_ON));
              add_byte(b);
              add_byte(8'h00);
            end
            CMD_PROGRAM: begin
              add_byte(on_chan(MIDI_PROG));
              add_byte(b);
            end
            CMD_BEND: begin
              add_byte(on_chan(MIDI_BEND));
              add_byte(8'h00);
              add_byte(b);
            end
            CMD_VOLUME: begin
              add_byte(on_chan(MIDI_CTRL));
              add_byte(CC_VOLUME);
              add_byte(b);
            end
            CMD_DRUM: begin
              add_byte(on_chan(MIDI_CTRL));
              add_byte(CC_DRUM);
              add_byte(b);
            end
            CMD_PAN: begin
              add_byte(on_chan(MIDI_CTRL));
              add_byte(CC_PAN);
              add_byte(b);
            end
            CMD_CTRL: begin
              add_byte(on_chan(MIDI_CTRL));
              add_byte(b);
              pend_cmd_q = CMD_CTRL_VALUE;
              phase_q    = PH_PARAM;
            end
            CMD_CTRL_VALUE: begin
              add_byte(b);
              pend_cmd_q = CMD_CTRL;
            end
            default: ;
          endcase
        end
      end
      // ended: nothing until the next track start
      default: ;
    endcase
    for (int i = 0; i < run_q.size(); i++) begin
      e      = run_q[i];
      e.last = (i == run_q.size() - 1);
      e.done = e.last & run_done;
      expected_bytes_q.push_back(e);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] exp_v,
                                 input logic [7:0] got_v);
    $display("checker: %s at result %0d: expected %02h, got %02h",
             what, checked_o, exp_v, got_v);
    mismatches_o++;
  endtask

  // compare output transactions, then predict from input transactions
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      = PH_DELAY;
      pend_cmd_q   = 8'h00;
      chan_q       = 4'h0;
      prev_note_q  = NO_NOTE;
      expected_bytes_q.delete();
      mismatches_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_bytes_q.size() == 0) begin
          report_mismatch("result with nothing expected", 8'h00, out_byte_i);
        end else begin
          want = expected_bytes_q.pop_front();
          if (out_byte_i !== want.value)
            report_mismatch("out_byte", want.value, out_byte_i);
          if (last_of_run_i !== want.last)
            report_mismatch("last_of_run", {7'd0, want.last}, {7'd0, last_of_run_i});
          if (track_done_i !== want.done)
            report_mismatch("track_done", {7'd0, want.done}, {7'd0, track_done_i});
          if (unknown_command_i !== want.unk)
            report_mismatch("unknown_command", {7'd0, want.unk}, {7'd0, unknown_command_i});
          if (double_note_off_i !== want.dno)
            report_mismatch("double_note_off", {7'd0, want.dno}, {7'd0, double_note_off_i});
          checked_o++;
        end
      end
      if (in_valid_i && !in_stall_i) predict_midi_run(data_byte_i, track_start_i);
      pending_o = expected_bytes_q.size();
    end
  end

endmodule

`default_nettype wire

@@ sim/music_event_to_midi_transcoder_top_tb.sv @@
`default_nettype none

module music_event_to_midi_transcoder_top_tb
  import mevmidi_pkg::*;
;

  localparam int unsigned RANDOM_ITEMS = 124;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned DIRECTED_N   = 46;

  // channel select commands occupy 80..8f
  localparam logic [7:0] CMD_CHAN_SEL = 8'h80;

  localparam logic [7:0] ONE_PARAM_CMDS [6] = '{
    CMD_NOTE_OFF, CMD_PROGRAM, CMD_BEND, CMD_VOLUME, CMD_DRUM, CMD_PAN
  };
  // command codes with no meaning below a0
  localparam logic [7:0] UNUSED_CMDS [5] = '{
    8'h93, 8'h94, 8'h9A, CMD_CTRL_VALUE, 8'h9F
  };

  // bit 8 is track_start, bits 7:0 the source byte
  localparam logic [8:0] DIRECTED_SEQ [DIRECTED_N] = '{
    9'h100, {1'b0, CMD_LAST_OFF},                      // note off with no note
    9'h07F, 9'h03C, 9'h000,                             // note, lowest velocity
    9'h080, 9'h000, 9'h03C, 9'h0FF,                     // long delay, repeated note
    9'h000, {1'b0, CMD_CHAN_SEL | 8'h0F},
    9'h000, {1'b0, CMD_PROGRAM}, 9'h080,
    9'h000, {1'b0, CMD_BEND}, 9'h07F,
    9'h000, {1'b0, CMD_VOLUME}, 9'h0FF,
    9'h000, {1'b0, CMD_DRUM}, 9'h001,
    9'h000, {1'b0, CMD_PAN}, 9'h040,
    9'h000, {1'b0, CMD_CTRL}, 9'h07F, 9'h0FF,
    9'h000, {1'b0, CMD_LOOP_START},
    9'h000, {1'b0, CMD_LAST_OFF},                       // note still sounding
    9'h000, {1'b0, CMD_NOTE_OFF}, 9'h07F,
    9'h000, 9'h0FF, {1'b0, CMD_CTRL_VALUE},             // two unknown commands
    {1'b0, CMD_TRACK_END}, 9'h0FF,                      // byte after end is ignored
    9'h17F, {1'b0, CMD_CHAN_SEL}, 9'h000, {1'b0, CMD_LOOP_BACK}
  };

  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_byte_i   = 8'h00;
  logic       track_start_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i   = 1'b0;
  logic [7:0] out_byte_o;
  logic       last_of_run_o;
  logic       track_done_o;
  logic       unknown_command_o;
  logic       double_note_off_o;

  int mismatches;
  int pending_results;
  int checked_results;

  int cycle_count = 0;
  int stall_left  = 0;
  int src_items   = 0;
  int junk_items  = 0;
  int track_starts = 0;
  int event_count = 0;
  int drain_pauses = 0;
  logic       need_start = 1'b0;
  logic [7:0] last_note  = 8'h3C;

  music_event_to_midi_transcoder_top DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .data_byte_i       (data_byte_i),
    .track_start_i     (track_start_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_byte_o        (out_byte_o),
    .last_of_run_o     (last_of_run_o),
    .track_done_o      (track_done_o),
    .unknown_command_o (unknown_command_o),
    .double_note_off_o (double_note_off_o)
  );

  midi_stream_checker midi_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .data_byte_i       (data_byte_i),
    .track_start_i     (track_start_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_byte_i        (out_byte_o),
    .last_of_run_i     (last_of_run_o),
    .track_done_i      (track_done_o),
    .unknown_command_i (unknown_command_o),
    .double_note_off_i (double_note_off_o),
    .mismatches_o      (mismatches),
    .pending_o         (pending_results),
    .checked_o         (checked_results)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("music_event_to_midi_transcoder_top: mismatch");
      $finish;
    end
  end

  // receiver stalls, with quiet windows
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (((cycle_count / 400) % 5 == 0) || ($urandom_range(0, 99) < 70)) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= 1'b1;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
    end
  end

  // sender gap: mostly none or short, a few long, none in quiet stretches
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (event_count % 16 < 3) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one input transaction, called and returning at a falling edge
  task automatic send_src_byte(input logic [7:0] d, input logic s);
    int unsigned gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= d;
    track_start_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    src_items++;
    if (s) track_starts++;
    @(negedge clk_i);
  endtask

  // hold off the sender until every expected byte has come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_results != 0) @(negedge clk_i);
    drain_pauses++;
  endtask

  function automatic logic [7:0] pick_note();
    if ($urandom_range(0, 2) != 0) last_note = 8'($urandom_range(0, 127));
    return last_note;
  endfunction

  function automatic logic [7:0] pick_unknown();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(8'hA0, 8'hFF));
    return UNUSED_CMDS[$urandom_range(0, 4)];
  endfunction

  // one well-formed event with random content, sometimes noise or a broken end
  task automatic send_event();
    int unsigned pick;
    int unsigned n;
    logic        start;
    start      = need_start || ($urandom_range(0, 11) == 0);
    need_start = 1'b0;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    // delay bytes
    repeat (n) begin
      send_src_byte({1'b1, 7'($urandom_range(0, 127))}, start);
      start = 1'b0;
    end
    send_src_byte({1'b0, 7'($urandom_range(0, 127))}, start);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      send_src_byte(pick_note(), 1'b0);
      send_src_byte(8'($urandom), 1'b0);
    end else if (pick < 50) begin
      send_src_byte(CMD_CHAN_SEL | {4'h0, 4'($urandom)}, 1'b0);
    end else if (pick < 72) begin
      send_src_byte(ONE_PARAM_CMDS[$urandom_range(0, 5)], 1'b0);
      send_src_byte(8'($urandom), 1'b0);
    end else if (pick < 79) begin
      send_src_byte(CMD_CTRL, 1'b0);
      send_src_byte(8'($urandom), 1'b0);
      send_src_byte(8'($urandom), 1'b0);
    end else if (pick < 83) begin
      send_src_byte(CMD_LOOP_START, 1'b0);
    end else if (pick < 88) begin
      send_src_byte(CMD_LAST_OFF, 1'b0);
    end else if (pick < 93) begin
      // unknown commands, then a note
      repeat ($urandom_range(1, 2)) send_src_byte(pick_unknown(), 1'b0);
      send_src_byte(pick_note(), 1'b0);
      send_src_byte(8'($urandom), 1'b0);
    end else if (pick < 96) begin
      send_src_byte(($urandom_range(0, 1) == 0) ? CMD_TRACK_END : CMD_LOOP_BACK, 1'b0);
      // bytes after the end are ignored
      repeat ($urandom_range(0, 2)) begin
        send_src_byte(8'($urandom), 1'b0);
        junk_items++;
      end
      need_start = 1'b1;
    end else begin
      // noise, then a fresh track
      repeat ($urandom_range(1, 3)) send_src_byte(8'($urandom), $urandom_range(0, 3) == 0);
      need_start = 1'b1;
    end
  endtask

  // stimulus and verdict
  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < DIRECTED_N; i++)
      send_src_byte(DIRECTED_SEQ[i][7:0], DIRECTED_SEQ[i][8]);
    need_start = 1'b1;
    while (src_items - junk_items < DIRECTED_N + RANDOM_ITEMS) begin
      if (event_count == 15 || event_count == 45) drain_results();
      send_event();
      event_count++;
    end
    in_valid_i <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("covered %0d source bytes (%0d random events, %0d track starts, %0d pauses)",
             src_items, event_count, track_starts, drain_pauses);
    $display("compared %0d midi bytes, %0d field mismatches", checked_results, mismatches);
    if (mismatches == 0) begin
      $display("music_event_to_midi_transcoder_top: match");
    end else begin
      $display("music_event_to_midi_transcoder_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
